// ===== sv/banded_dtw_accumulated_cost_defines.svh =====
// Assertion macros shared by the banded DTW accumulated-cost block.
`ifndef BANDED_DTW_ACCUMULATED_COST_DEFINES_SVH
`define BANDED_DTW_ACCUMULATED_COST_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, quiet while rst_ni is low.
`define BDAC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, quiet while rst_ni is low.
`define BDAC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/bdac_pkg.sv =====
// Types and constants for the banded DTW accumulated-cost block.
package bdac_pkg;

  localparam int COST_WIDTH     = 16;
  localparam int ACC_WIDTH      = 32;
  localparam int START_WIDTH    = 20;
  localparam int CFG_WIDTH      = 9;
  localparam int COL_OUT_WIDTH  = 8;
  localparam int BAND_RESET     = 64;

  localparam logic [ACC_WIDTH-1:0] ACC_INF = {ACC_WIDTH{1'b1}};

  typedef struct packed {
    logic [COST_WIDTH-1:0]  cell_cost;
    logic [START_WIDTH-1:0] band_start;
    logic                   matrix_start;
  } in_item_t;

  typedef struct packed {
    logic [ACC_WIDTH-1:0]     acc_cost;
    logic [COL_OUT_WIDTH-1:0] band_column;
    logic                     row_last;
  } out_item_t;

  // Control carried from the address stage to the accumulate stage.
  typedef struct packed {
    logic [COST_WIDTH-1:0] cost;
    logic                  first_row;
    logic                  col_zero;
    logic                  row_last;
    logic                  up_ok;
    logic                  dg_ok;
    logic                  fwd_up;
    logic                  fwd_dg;
    logic                  bank;
  } cell_ctl_t;

endpackage

// ===== sv/banded_dtw_accumulated_cost.sv =====
// Banded DTW accumulated cost: one cell a cycle while the consumer does not stall.
// Throughput: one beat per cycle sustained unless the consumer stalls; its back-pressure is the only limit.
// Order: address and read in the accept cycle, then add and write-back in stage two once the
// output register is free, then the result held in the output register.
// Reset clears the valid flags, row and column tracking and bank; band width returns to 64 (limited to MAX_BAND).
// The row store is not cleared: entries are undefined until a row writes them.
`include "banded_dtw_accumulated_cost_defines.svh"

module banded_dtw_accumulated_cost #(
  parameter int MAX_BAND = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Band width register write
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bdac_pkg::CFG_WIDTH-1:0] cfg_data_i,
  // Cell input
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  bdac_pkg::in_item_t             in_data_i,
  // Accumulated cost output
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output bdac_pkg::out_item_t            out_data_o
);

  localparam int IW    = $clog2(MAX_BAND);
  localparam int DEPTH = 2 ** (IW + 1);

  // Stage one to stage two.
  logic                           s1_valid;
  bdac_pkg::cell_ctl_t            s1_ctl;
  logic [IW-1:0]                  s1_col;
  logic                           s1_adv;

  // Row store traffic. Two copies of the store, written alike, give the up and
  // diagonal reads a port each.
  logic                           rd_en;
  logic [IW:0]                    rd_up_addr, rd_dg_addr;
  logic [bdac_pkg::ACC_WIDTH-1:0] rd_up, rd_dg;
  logic                           wr_en;
  logic [IW:0]                    wr_addr;
  logic [bdac_pkg::ACC_WIDTH-1:0] wr_data;

  // Width writes must arrive only while idle; the block does not check and takes each beat at once.
  assign cfg_ready_o = 1'b1;

  // Stage one: track the column and row, pick the band offset, launch both reads.
  // The store is banked by row: the current row writes one bank and reads the
  // other, and the bank flips on each last cell.
  bdac_addr #(
    .MAX_BAND (MAX_BAND)
  ) u_addr (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i && cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_data_i    (in_data_i),
    .in_stall_o   (in_stall_o),
    .s1_adv_i     (s1_adv),
    .s1_valid_o   (s1_valid),
    .s1_ctl_o     (s1_ctl),
    .s1_col_o     (s1_col),
    .rd_en_o      (rd_en),
    .rd_up_addr_o (rd_up_addr),
    .rd_dg_addr_o (rd_dg_addr)
  );

  bdac_ram #(
    .WIDTH (bdac_pkg::ACC_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram_up (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_up_addr),
    .rd_data_o (rd_up)
  );

  bdac_ram #(
    .WIDTH (bdac_pkg::ACC_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram_dg (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_dg_addr),
    .rd_data_o (rd_dg)
  );

  // Stage two: minimum of up, left and diagonal (first row: left alone), saturating add, write back.
  // Left comes from the previous result register; a read that hits the cell being
  // written in the same cycle is replaced by that same register (forwarding).
  // The output register parts this stage from the consumer, so a new beat enters
  // while a finished one waits.
  bdac_acc #(
    .MAX_BAND (MAX_BAND)
  ) u_acc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s1_valid_i  (s1_valid),
    .s1_ctl_i    (s1_ctl),
    .s1_col_i    (s1_col),
    .rd_up_i     (rd_up),
    .rd_dg_i     (rd_dg),
    .s1_adv_o    (s1_adv),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  // Hold the input when both stages are full and the consumer stalls.
  `BDAC_ASSERT_NOW(a_full_holds_input, s1_valid && out_valid_o && out_stall_i, in_stall_o, "beat accepted with both stages full")
  // An accepted beat occupies stage two in the next cycle.
  `BDAC_ASSERT_NEXT(a_accept_fills_stage, in_valid_i && !in_stall_o, s1_valid, "accepted beat lost before stage two")
  // A write-back always produces a result beat in the next cycle.
  `BDAC_ASSERT_NEXT(a_write_gives_beat, wr_en, out_valid_o, "row store written without a result beat")
  // No result appears from an empty pipeline.
  `BDAC_ASSERT_NEXT(a_no_phantom_beat, !s1_valid && !out_valid_o, !out_valid_o, "result beat from empty pipeline")

endmodule

// ===== sv/bdac_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
module bdac_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== sv/bdac_addr.sv =====
// Address stage: row and column tracking, neighbour addresses, band width register.
module bdac_addr #(
  parameter int MAX_BAND = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic [bdac_pkg::CFG_WIDTH-1:0]    cfg_data_i,
  input  logic                              in_valid_i,
  input  bdac_pkg::in_item_t                in_data_i,
  output logic                              in_stall_o,
  input  logic                              s1_adv_i,
  output logic                              s1_valid_o,
  output bdac_pkg::cell_ctl_t               s1_ctl_o,
  output logic [$clog2(MAX_BAND)-1:0]       s1_col_o,
  output logic                              rd_en_o,
  output logic [$clog2(MAX_BAND):0]         rd_up_addr_o,
  output logic [$clog2(MAX_BAND):0]         rd_dg_addr_o
);

  localparam int IW     = $clog2(MAX_BAND);
  localparam int WW     = $clog2(MAX_BAND + 1);
  localparam int CW     = (WW > bdac_pkg::CFG_WIDTH) ? WW : bdac_pkg::CFG_WIDTH;
  localparam int SW     = bdac_pkg::START_WIDTH + 1;
  localparam int WRESET = (bdac_pkg::BAND_RESET > MAX_BAND) ? MAX_BAND : bdac_pkg::BAND_RESET;

  logic [WW-1:0]                     band_w_q;
  logic [IW-1:0]                     col_q, col_d;
  logic [bdac_pkg::START_WIDTH-1:0]  rbs_q, pbs_q;
  logic                              first_q, first_d;
  logic                              bank_q;
  logic                              s1_valid_q;
  bdac_pkg::cell_ctl_t               s1_ctl_q, ctl_d;
  logic [IW-1:0]                     s1_col_q;

  logic [CW-1:0]                     cfg_ext, cfg_clamped;
  logic                              accept;
  logic [IW-1:0]                     col;
  logic                              row_begin;
  logic [bdac_pkg::START_WIDTH-1:0]  rbs_cur, pbs_cur, offset;
  logic                              rising;
  logic [SW-1:0]                     p, pm1, w_ext, col_next;
  logic                              last;
  logic [IW:0]                       up_addr, dg_addr;

  // Clamp the written width into 1..MAX_BAND.
  always_comb begin
    cfg_ext = CW'(cfg_data_i);
    if (cfg_ext == '0) begin
      cfg_clamped = CW'(1);
    end else if (cfg_ext > CW'(MAX_BAND)) begin
      cfg_clamped = CW'(MAX_BAND);
    end else begin
      cfg_clamped = cfg_ext;
    end
  end

  assign in_stall_o = s1_valid_q && !s1_adv_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    col       = in_data_i.matrix_start ? '0 : col_q;
    row_begin = (col == '0);
    rbs_cur   = row_begin ? in_data_i.band_start : rbs_q;
    pbs_cur   = row_begin ? rbs_q : pbs_q;
    first_d   = in_data_i.matrix_start | first_q;
    rising    = (rbs_cur >= pbs_cur);
    offset    = rbs_cur - pbs_cur;
    p         = {1'b0, offset} + SW'(col);
    pm1       = p - SW'(1);
    w_ext     = SW'(band_w_q);
    col_next  = SW'(col) + SW'(1);
    last      = (col_next >= w_ext);
    col_d     = last ? '0 : IW'(col_next);
    up_addr   = {~bank_q, p[IW-1:0]};
    dg_addr   = {~bank_q, pm1[IW-1:0]};

    ctl_d.cost      = in_data_i.cell_cost;
    ctl_d.first_row = first_d;
    ctl_d.col_zero  = row_begin;
    ctl_d.row_last  = last;
    ctl_d.up_ok     = !first_d && rising && (p < w_ext);
    ctl_d.dg_ok     = !first_d && rising && (p != '0) && (p <= w_ext);
    // The cell now in the accumulate stage writes at this very edge: take its value.
    ctl_d.fwd_up    = s1_valid_q && (up_addr == {s1_ctl_q.bank, s1_col_q});
    ctl_d.fwd_dg    = s1_valid_q && (dg_addr == {s1_ctl_q.bank, s1_col_q});
    ctl_d.bank      = bank_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_w_q   <= WW'(WRESET);
      col_q      <= '0;
      rbs_q      <= '0;
      pbs_q      <= '0;
      first_q    <= 1'b1;
      bank_q     <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        band_w_q <= WW'(cfg_clamped);
      end
      if (accept) begin
        col_q   <= col_d;
        first_q <= last ? 1'b0 : first_d;
        bank_q  <= bank_q ^ last;
        if (row_begin) begin
          rbs_q <= in_data_i.band_start;
          pbs_q <= rbs_q;
        end
      end
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv_i) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_ctl_q <= ctl_d;
      s1_col_q <= col;
    end
  end

  assign s1_valid_o   = s1_valid_q;
  assign s1_ctl_o     = s1_ctl_q;
  assign s1_col_o     = s1_col_q;
  assign rd_en_o      = accept;
  assign rd_up_addr_o = up_addr;
  assign rd_dg_addr_o = dg_addr;

endmodule

// ===== sv/bdac_acc.sv =====
// Accumulate stage: three-way minimum, saturating add, write-back and output register.
module bdac_acc #(
  parameter int MAX_BAND = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s1_valid_i,
  input  bdac_pkg::cell_ctl_t               s1_ctl_i,
  input  logic [$clog2(MAX_BAND)-1:0]       s1_col_i,
  input  logic [bdac_pkg::ACC_WIDTH-1:0]    rd_up_i,
  input  logic [bdac_pkg::ACC_WIDTH-1:0]    rd_dg_i,
  output logic                              s1_adv_o,
  output logic                              wr_en_o,
  output logic [$clog2(MAX_BAND):0]         wr_addr_o,
  output logic [bdac_pkg::ACC_WIDTH-1:0]    wr_data_o,
  input  logic                              out_stall_i,
  output logic                              out_valid_o,
  output bdac_pkg::out_item_t               out_data_o
);

  localparam int AW = bdac_pkg::ACC_WIDTH;

  logic [AW-1:0]       left_q;
  logic                out_valid_q;
  bdac_pkg::out_item_t out_data_q;

  logic                fire;
  logic [AW-1:0]       cost_ext, up, dg, left, m1, m2, addend, acc;
  logic [AW:0]         sum;

  assign s1_adv_o = !out_valid_q || !out_stall_i;
  assign fire     = s1_valid_i && s1_adv_o;

  always_comb begin
    cost_ext = AW'(s1_ctl_i.cost);
    up       = !s1_ctl_i.up_ok ? bdac_pkg::ACC_INF : (s1_ctl_i.fwd_up ? left_q : rd_up_i);
    dg       = !s1_ctl_i.dg_ok ? bdac_pkg::ACC_INF : (s1_ctl_i.fwd_dg ? left_q : rd_dg_i);
    left     = s1_ctl_i.col_zero ? bdac_pkg::ACC_INF : left_q;
    m1       = (left < up) ? left : up;
    m2       = (dg < m1) ? dg : m1;
    if (s1_ctl_i.first_row) begin
      addend = s1_ctl_i.col_zero ? '0 : left_q;
    end else begin
      addend = m2;
    end
    sum = {1'b0, addend} + {1'b0, cost_ext};
    acc = sum[AW] ? bdac_pkg::ACC_INF : sum[AW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        left_q <= acc;
      end
      if (s1_adv_o) begin
        out_valid_q <= s1_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_data_q.acc_cost    <= acc;
      out_data_q.band_column <= bdac_pkg::COL_OUT_WIDTH'(s1_col_i);
      out_data_q.row_last    <= s1_ctl_i.row_last;
    end
  end

  assign wr_en_o     = fire;
  assign wr_addr_o   = {s1_ctl_i.bank, s1_col_i};
  assign wr_data_o   = acc;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
